### src/itoa_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned HEX_DIGITS = 16;
  localparam int unsigned DEC19_DIGS = 19;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned BITCNT_W   = 6;

  localparam logic [OP_W-1:0] OP_HEX_SHORT = 3'd0;
  localparam logic [OP_W-1:0] OP_HEX_FULL  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEC_U     = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC_S     = 3'd3;
  localparam logic [OP_W-1:0] OP_DEC19     = 3'd4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_A_OFS = 8'h57;  // 'a' - 10

  localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(VALUE_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d, input logic hex);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0, d};
    if (hex && (d > 4'd9)) begin
      digit_ascii = ASCII_A_OFS + ext;
    end else begin
      digit_ascii = ASCII_ZERO + ext;
    end
  endfunction

endpackage

`default_nettype wire

### src/itoa_if.sv
// Valid/ready channel interfaces for the formatter's input and output words.
// Depends on itoa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface itoa_in_if;
  logic                           valid;
  logic                           ready;
  logic [itoa_pkg::VALUE_W-1:0]   value;
  logic [itoa_pkg::OP_W-1:0]      operation;

  modport source (output valid, output value, output operation, input ready);
  modport sink   (input valid, input value, input operation, output ready);
endinterface

interface itoa_out_if;
  logic                           valid;
  logic                           ready;
  logic [itoa_pkg::CHAR_W-1:0]    character;
  logic                           last;
  logic                           overflow;

  modport source (output valid, output character, output last, output overflow, input ready);
  modport sink   (input valid, input character, input last, input overflow, output ready);
endinterface

`default_nettype wire

### src/itoa_dabble.sv
// One shift-and-add-3 step of binary to BCD conversion over 20 digits.
// Depends on itoa_pkg for the BCD width.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dabble (
  input  wire logic [itoa_pkg::BCD_W-1:0] bcd_i,
  input  wire logic                       bit_i,
  output logic      [itoa_pkg::BCD_W-1:0] bcd_o
);

  logic [itoa_pkg::BCD_W-1:0] adj;

  // Correct every digit that would pass nine after the doubling.
  always_comb begin
    for (int k = 0; k < int'(itoa_pkg::DEC_DIGITS); k++) begin
      if (bcd_i[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_i[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_i[4*k +: 4];
      end
    end
  end

  assign bcd_o = {adj[itoa_pkg::BCD_W-2:0], bit_i};

endmodule

`default_nettype wire

### src/integer_to_ascii_formatter.sv
// Hex formats: the value is loaded on acceptance, then one character per cycle while the
// output is not stalled (16 max; short hex drops leading zeros without output).
// Decimal formats: load, shared shift-and-add-3 over all value bits, then up to 20 characters.
// One value at a time; for a known operation, ready is low until its last character is queued.
// rst_ni asynchronously clears sequencer, digit count and output valid flag; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itoa_in_if.sink   in_i,
  itoa_out_if.source out_o
);

  itoa_pkg::state_e state_q, state_d;

  // Digit register: hex nibbles or BCD accumulator, then shifted out from its top nibble.
  logic [itoa_pkg::BCD_W-1:0]    dig_q, dig_d;
  // Binary operand, shifted out from its top bit into the BCD step.
  logic [itoa_pkg::VALUE_W-1:0]  bin_q, bin_d;
  logic [itoa_pkg::BITCNT_W-1:0] bit_q, bit_d;
  // Digits still to shift out of the top of dig_q.
  logic [itoa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [itoa_pkg::OP_W-1:0]     op_q, op_d;
  logic                          lead_q, lead_d;   // still suppressing leading zeros
  logic                          hex_q, hex_d;
  logic                          neg_q, neg_d;
  logic                          ovf_q, ovf_d;

  // Output register.
  logic                          ovalid_q, ovalid_d;
  logic [itoa_pkg::CHAR_W-1:0]   ochar_q, ochar_d;
  logic                          olast_q, olast_d;
  logic                          oovf_q, oovf_d;

  logic [itoa_pkg::BCD_W-1:0]    dab;
  logic [3:0]                    top;
  logic                          out_free;
  logic                          skip;
  logic                          accept;
  logic                          op_known;

  itoa_dabble u_dabble (
    .bcd_i (dig_q),
    .bit_i (bin_q[itoa_pkg::VALUE_W-1]),
    .bcd_o (dab)
  );

  assign top      = dig_q[itoa_pkg::BCD_W-1 -: 4];
  assign out_free = !ovalid_q || out_o.ready;
  // Drop a leading zero, but never the final digit.
  assign skip     = lead_q && (top == 4'd0) && (cnt_q != itoa_pkg::CNT_W'(1));
  assign accept   = in_i.valid && in_i.ready;
  assign op_known = (in_i.operation inside {itoa_pkg::OP_HEX_SHORT, itoa_pkg::OP_HEX_FULL,
                                            itoa_pkg::OP_DEC_U, itoa_pkg::OP_DEC_S,
                                            itoa_pkg::OP_DEC19});

  assign in_i.ready      = (state_q == itoa_pkg::ST_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.character = ochar_q;
  assign out_o.last      = olast_q;
  assign out_o.overflow  = oovf_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (accept && op_known) begin
          if ((in_i.operation == itoa_pkg::OP_HEX_SHORT) ||
              (in_i.operation == itoa_pkg::OP_HEX_FULL)) begin
            state_d = itoa_pkg::ST_EMIT;
          end else begin
            state_d = itoa_pkg::ST_CONV;
          end
        end
      end
      itoa_pkg::ST_CONV: begin
        if (bit_q == itoa_pkg::LAST_BIT) begin
          state_d = neg_q ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (!skip && out_free && (cnt_q == itoa_pkg::CNT_W'(1))) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    dig_d    = dig_q;
    bin_d    = bin_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    lead_d   = lead_q;
    hex_d    = hex_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    oovf_d   = oovf_q;
    ovalid_d = ovalid_q && !out_o.ready;

    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (accept) begin
          op_d  = in_i.operation;
          bit_d = '0;
          neg_d = 1'b0;
          ovf_d = 1'b0;
          case (in_i.operation)
            itoa_pkg::OP_HEX_SHORT, itoa_pkg::OP_HEX_FULL: begin
              // Top-align the 16 nibbles in the digit register.
              dig_d  = {in_i.value, {(itoa_pkg::BCD_W - itoa_pkg::VALUE_W){1'b0}}};
              cnt_d  = itoa_pkg::CNT_W'(itoa_pkg::HEX_DIGITS);
              hex_d  = 1'b1;
              lead_d = (in_i.operation == itoa_pkg::OP_HEX_SHORT);
            end
            itoa_pkg::OP_DEC_S: begin
              dig_d  = '0;
              neg_d  = in_i.value[itoa_pkg::VALUE_W-1];
              // Magnitude; the most negative value maps onto 2^63 unsigned.
              bin_d  = in_i.value[itoa_pkg::VALUE_W-1] ? (~in_i.value + 64'd1) : in_i.value;
              cnt_d  = itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS);
              hex_d  = 1'b0;
              lead_d = 1'b1;
            end
            default: begin
              // Unsigned and fixed-width decimal; unknown codes are dropped by the FSM.
              dig_d  = '0;
              bin_d  = in_i.value;
              cnt_d  = itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS);
              hex_d  = 1'b0;
              lead_d = (in_i.operation != itoa_pkg::OP_DEC19);
            end
          endcase
        end
      end
      itoa_pkg::ST_CONV: begin
        dig_d = dab;
        bin_d = {bin_q[itoa_pkg::VALUE_W-2:0], 1'b0};
        bit_d = bit_q + itoa_pkg::BITCNT_W'(1);
        if ((bit_q == itoa_pkg::LAST_BIT) && (op_q == itoa_pkg::OP_DEC19)) begin
          // Top digit is 0 or 1: it is the overflow flag, and dropping it leaves x mod 10^19.
          ovf_d = (dab[itoa_pkg::BCD_W-1 -: 4] != 4'd0);
          dig_d = {dab[itoa_pkg::BCD_W-5:0], 4'd0};
          cnt_d = itoa_pkg::CNT_W'(itoa_pkg::DEC19_DIGS);
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = itoa_pkg::ASCII_MINUS;
          olast_d  = 1'b0;
          oovf_d   = 1'b0;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (skip) begin
          dig_d = {dig_q[itoa_pkg::BCD_W-5:0], 4'd0};
          cnt_d = cnt_q - itoa_pkg::CNT_W'(1);
        end else if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = itoa_pkg::digit_ascii(top, hex_q);
          olast_d  = (cnt_q == itoa_pkg::CNT_W'(1));
          oovf_d   = ovf_q;
          lead_d   = 1'b0;
          dig_d    = {dig_q[itoa_pkg::BCD_W-5:0], 4'd0};
          cnt_d    = cnt_q - itoa_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= itoa_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    bin_q   <= bin_d;
    bit_q   <= bit_d;
    op_q    <= op_d;
    lead_q  <= lead_d;
    hex_q   <= hex_d;
    neg_q   <= neg_d;
    ovf_q   <= ovf_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

  // Overflow is only ever flagged on decimal digit characters.
  a_ovf_dec19: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |->
      ((out_o.character >= itoa_pkg::ASCII_ZERO) &&
       (out_o.character <= (itoa_pkg::ASCII_ZERO + 8'd9))))
    else $error("overflow flagged on a non-digit character");

  // A known operation takes the block busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_known) |=> !in_i.ready)
    else $error("ready stayed high after accepting a value");

  // Emission never runs with an empty digit count.
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_pkg::ST_EMIT) |-> (cnt_q != itoa_pkg::CNT_W'(0)))
    else $error("emit state with no digits left");

  // The minus sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.character == itoa_pkg::ASCII_MINUS)) |-> !out_o.last)
    else $error("minus sign marked as last character");

endmodule

`default_nettype wire

### dv/itoa_text_checker.sv
// Checker for the integer-to-ASCII formatter: watches both channels, predicts the text
// of every accepted value word and compares it character by character.
// Depends on itoa_pkg and the channel interfaces in itoa_if.
`timescale 1ns / 1ps

module itoa_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if          in_mon,
  itoa_out_if         out_mon,
  output int unsigned mismatches_o,
  output int unsigned chars_pending_o
);

  import itoa_pkg::*;

  localparam logic [VALUE_W-1:0] TEN_POW_19 = 64'd10000000000000000000;
  localparam logic [CHAR_W-1:0]  CH_ZERO    = "0";
  localparam logic [CHAR_W-1:0]  CH_LOWER_A = "a";
  localparam logic [CHAR_W-1:0]  CH_MINUS   = "-";

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              overflow;
  } text_char_t;

  text_char_t  expected_text [$];
  int unsigned mismatch_count = 0;

  assign mismatches_o    = mismatch_count;
  assign chars_pending_o = expected_text.size();

  // Append the characters that one value word must produce.
  function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                       input logic [OP_W-1:0] op);
    logic [CHAR_W-1:0] chars [$];
    logic [VALUE_W-1:0] mag;
    logic [3:0]         nib;
    logic               ovf;
    logic               seen;
    text_char_t         entry;
    ovf  = 1'b0;
    seen = 1'b0;
    case (op)
      OP_HEX_SHORT, OP_HEX_FULL: begin
        for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
          nib = value[4*i +: 4];
          if (op == OP_HEX_FULL || seen || nib != 4'd0) begin
            chars.insert(chars.size(), nib < 4'd10 ? CH_ZERO + CHAR_W'(nib)
                                                   : CH_LOWER_A + CHAR_W'(nib) - 8'd10);
            seen = 1'b1;
          end
        end
        if (chars.size() == 0) chars.insert(0, CH_ZERO);
      end
      OP_DEC_U, OP_DEC_S: begin
        mag = (op == OP_DEC_S && value[VALUE_W-1]) ? ~value + 64'd1 : value;
        do begin
          chars.push_front(CH_ZERO + CHAR_W'(mag % 64'd10));
          mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (op == OP_DEC_S && value[VALUE_W-1]) chars.push_front(CH_MINUS);
      end
      OP_DEC19: begin
        mag = value;
        if (value >= TEN_POW_19) begin
          ovf = 1'b1;
          mag = value - TEN_POW_19;
        end
        repeat (DEC19_DIGS) begin
          chars.push_front(CH_ZERO + CHAR_W'(mag % 64'd10));
          mag = mag / 64'd10;
        end
      end
      default: ;  // unused selectors print nothing
    endcase
    foreach (chars[i]) begin
      entry.character = chars[i];
      entry.last      = (i == chars.size() - 1);
      entry.overflow  = ovf;
      expected_text.insert(expected_text.size(), entry);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    text_char_t want;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) predict_text(in_mon.value, in_mon.operation);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected word: character %h last %b overflow %b",
                 out_mon.character, out_mon.last, out_mon.overflow);
          mismatch_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_mon.character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_mon.character);
            mismatch_count++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_mon.last);
            mismatch_count++;
          end
          if (out_mon.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, out_mon.overflow);
            mismatch_count++;
          end
        end
      end
    end
  end

endmodule

### dv/tb_integer_to_ascii_formatter.sv
// Top of the integer-to-ASCII formatter testbench: clock, reset, value stimulus,
// output back-pressure, stall watchdog and verdict. Depends on itoa_pkg, itoa_if,
// the formatter itself and itoa_text_checker.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

  import itoa_pkg::*;

  localparam logic [VALUE_W-1:0] TEN_POW_19   = 64'd10000000000000000000;
  localparam logic [VALUE_W-1:0] ALL_ONES     = '1;
  localparam logic [VALUE_W-1:0] MOST_NEG     = 64'h8000_0000_0000_0000;
  localparam int unsigned        RANDOM_WORDS = 180;
  // Even for a decimal word and a stalled receiver, the gap between handshakes stays well
  // below this.
  localparam int unsigned        STALL_LIMIT  = 4000;
  // Let an ignored selector or a stray trailing character show up before the verdict.
  localparam int unsigned        DRAIN_CYCLES = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          steady = 1'b0;   // suppress idling on both sides
  int unsigned stall_cycles = 0;
  int unsigned mismatches;
  int unsigned chars_pending;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  integer_to_ascii_formatter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  itoa_text_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches_o    (mismatches),
    .chars_pending_o (chars_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: drop ready in about a third of the cycles, never while steady.
  always @(negedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 36);
  end

  // Watchdog: give up when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one value word, called at a falling edge; return at the falling edge after
  // acceptance. Valid stays high into the next word when no idle cycle is drawn.
  task automatic send_word(input logic [VALUE_W-1:0] value, input logic [OP_W-1:0] op);
    while (!steady && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= value;
    in_ch.operation <= op;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] pow10;
    int unsigned        counted;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.operation = OP_HEX_SHORT;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes and the corner cases of each format.
    send_word(64'd0, OP_HEX_SHORT);                     // zero prints a single '0'
    send_word(64'd1, OP_HEX_SHORT);
    send_word(64'h0123_4567_89ab_cdef, OP_HEX_SHORT);   // one leading zero to drop
    send_word(ALL_ONES, OP_HEX_SHORT);
    send_word(64'd0, OP_HEX_FULL);
    send_word(ALL_ONES, OP_HEX_FULL);
    send_word(64'd0, OP_DEC_U);
    send_word(TEN_POW_19 - 64'd1, OP_DEC_U);
    send_word(ALL_ONES, OP_DEC_U);                      // longest text, 20 digits
    send_word(64'd0, OP_DEC_S);
    send_word(MOST_NEG, OP_DEC_S);                      // most negative value
    send_word(ALL_ONES, OP_DEC_S);                      // minus one
    send_word(MOST_NEG - 64'd1, OP_DEC_S);
    send_word(64'd0, OP_DEC19);
    send_word(TEN_POW_19 - 64'd1, OP_DEC19);
    send_word(TEN_POW_19, OP_DEC19);                    // first overflowing value
    send_word(ALL_ONES, OP_DEC19);
    send_word(64'h5555_5555_5555_5555, 3'd5);           // unused selectors
    send_word(64'haaaa_aaaa_aaaa_aaaa, 3'd6);
    send_word(ALL_ONES, 3'd7);

    // Random: mix of raw values and values near the digit-count boundaries.
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      steady = (counted >= 70 && counted < 120);   // long stretch without idling
      case ($urandom_range(7))
        0, 7: value = {$urandom, $urandom};
        1: value = {$urandom, $urandom} >> $urandom_range(63);
        2: value = 64'($urandom_range(1000));
        3: value = TEN_POW_19 - 64'd64 + 64'($urandom_range(128));
        4: value = MOST_NEG - 64'd64 + 64'($urandom_range(128));
        5: begin
          pow10 = 64'd1;
          repeat ($urandom_range(19)) pow10 = pow10 * 64'd10;
          value = pow10 - 64'd1 + 64'($urandom_range(2));
        end
        default: value = ALL_ONES - 64'($urandom_range(255));
      endcase
      if ($urandom_range(99) < 6) begin
        op = OP_W'($urandom_range(7, 5));
      end else begin
        op = OP_W'($urandom_range(4));
        counted++;   // ignored selectors do not count toward the total
      end
      send_word(value, op);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain: wait for every predicted character, then hold a few more cycles.
    while (chars_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && chars_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### integer_to_ascii_formatter.f
src/itoa_pkg.sv
src/itoa_if.sv
src/itoa_dabble.sv
src/integer_to_ascii_formatter.sv
dv/itoa_text_checker.sv
dv/tb_integer_to_ascii_formatter.sv
